/* hw/rtl/dsc_pkg.sv */
// Shared types and constants for the distinct subsequence counter.
// Used by dsc_cell, dsc_or_tree and distinct_subsequence_counter.
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_SOURCE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_APPEND,
      OP_SOURCE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [7:0]  symbol;
      logic        last;
   } cell_ctrl_type;

   localparam int TREE_FANIN = 8;

endpackage

`default_nettype wire

/* hw/rtl/dsc_cell.sv */
// One pattern position: holds a target character, its prefix count and a wrap bit.
// Depends on dsc_pkg for the broadcast control word.
`timescale 1ns / 1ps
`default_nettype none

module dsc_cell #(
   parameter int COUNT_WIDTH = 32,
   parameter int LEN_W       = 8,
   parameter int INDEX       = 0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dsc_pkg::cell_ctrl_type    ctrl,
   input  wire logic [LEN_W-1:0]          length,
   input  wire logic [COUNT_WIDTH-1:0]    below_count,
   output logic      [COUNT_WIDTH-1:0]    count,
   output logic      [COUNT_WIDTH:0]      leaf
);
   import dsc_pkg::*;

   localparam logic [LEN_W-1:0] MY_IDX   = LEN_W'(INDEX);
   localparam logic [LEN_W-1:0] TAIL_LEN = LEN_W'(INDEX + 1);

   logic [7:0]             char_ff;
   logic [7:0]             char_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   wrap_ff;
   logic                   wrap_in;
   logic                   active;
   logic                   hit;
   logic [COUNT_WIDTH:0]   sum;
   logic [COUNT_WIDTH-1:0] new_count;
   logic                   new_wrap;

   assign active    = MY_IDX < length;
   assign hit       = active && (ctrl.op == OP_SOURCE) && (char_ff == ctrl.symbol);
   assign sum       = {1'b0, count_ff} + {1'b0, below_count};
   assign new_count = hit ? sum[COUNT_WIDTH-1:0] : count_ff;
   assign new_wrap  = wrap_ff | (hit & sum[COUNT_WIDTH]);

   always_comb begin
      char_in  = char_ff;
      count_in = count_ff;
      wrap_in  = wrap_ff;
      case (ctrl.op)
         OP_CLEAR: begin
            count_in = '0;
            wrap_in  = 1'b0;
         end
         OP_APPEND: begin
            if (length == MY_IDX) begin
               char_in  = ctrl.symbol;
               count_in = '0;
            end
         end
         OP_SOURCE: begin
            if (ctrl.last) begin
               count_in = '0;
               wrap_in  = 1'b0;
            end else begin
               count_in = new_count;
               wrap_in  = new_wrap;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      if (reset) begin
         count_ff <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         wrap_ff  <= wrap_in;
      end
   end

   assign count = count_ff;
   assign leaf  = {new_wrap, (length == TAIL_LEN) ? new_count : {COUNT_WIDTH{1'b0}}};

endmodule

`default_nettype wire

/* hw/rtl/dsc_or_tree.sv */
// Registered OR reduction tree that gathers the tail count and wrap bits of all cells.
// Depends on dsc_pkg for the tree fan-in.
`timescale 1ns / 1ps
`default_nettype none

module dsc_or_tree #(
   parameter int LEAVES = 128,
   parameter int WIDTH  = 33,
   parameter int SIDE_W = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [WIDTH-1:0]  leaf [LEAVES],
   input  wire logic [SIDE_W-1:0] side_in,
   output logic                   out_valid,
   output logic      [WIDTH-1:0]  out_data,
   output logic      [SIDE_W-1:0] side_out,
   output logic                   busy
);
   import dsc_pkg::*;

   function automatic int tree_levels(int leaves);
      int levels;
      int span;
      levels = 1;
      span   = TREE_FANIN;
      while (span < leaves) begin
         span   = span * TREE_FANIN;
         levels = levels + 1;
      end
      return levels;
   endfunction

   localparam int LEVELS = tree_levels(LEAVES);
   localparam int PAD    = TREE_FANIN ** LEVELS;

   logic [WIDTH-1:0]  leaf_pad [PAD];
   logic [WIDTH-1:0]  node_in  [LEVELS][PAD];
   logic [WIDTH-1:0]  node_ff  [LEVELS][PAD];
   logic [SIDE_W-1:0] side_ff  [LEVELS];
   logic [LEVELS-1:0] vld_ff;

   always_comb begin
      for (int i = 0; i < PAD; i++) begin
         leaf_pad[i] = '0;
         if (i < LEAVES) begin
            leaf_pad[i] = leaf[i];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         for (int n = 0; n < PAD; n++) begin
            node_in[l][n] = '0;
         end
      end
      for (int n = 0; n < PAD; n++) begin
         for (int c = 0; c < TREE_FANIN; c++) begin
            if (n * TREE_FANIN + c < PAD) begin
               node_in[0][n] = node_in[0][n] | leaf_pad[n * TREE_FANIN + c];
            end
         end
      end
      for (int l = 1; l < LEVELS; l++) begin
         for (int n = 0; n < PAD; n++) begin
            for (int c = 0; c < TREE_FANIN; c++) begin
               if (n * TREE_FANIN + c < PAD) begin
                  node_in[l][n] = node_in[l][n] | node_ff[l-1][n * TREE_FANIN + c];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LEVELS; l++) begin
         for (int n = 0; n < PAD; n++) begin
            node_ff[l][n] <= node_in[l][n];
         end
      end
      side_ff[0] <= side_in;
      for (int l = 1; l < LEVELS; l++) begin
         side_ff[l] <= side_ff[l-1];
      end
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_ff << 1) | LEVELS'(in_valid);
      end
   end

   assign out_valid = vld_ff[LEVELS-1];
   assign out_data  = node_ff[LEVELS-1][0];
   assign side_out  = side_ff[LEVELS-1];
   assign busy      = |vld_ff;

endmodule

`default_nettype wire

/* hw/rtl/distinct_subsequence_counter.sv */
// Distinct subsequence counter built as a row of per-position cells.
// Depends on dsc_pkg, dsc_cell and dsc_or_tree.
//
// Each request word carries an action in tuser, a character in tdata and a
// last marker in tlast. A clear word starts a new problem, append words add
// target characters one per cell, and source words update every matching prefix count
// in parallel, each cell taking its left neighbor's count as it was before the
// word. A source word with tlast set produces one response word: the count for
// the whole target in tdata and the wrap and target overflow flags in tuser, and
// clears all counts and wrap bits. Every other word produces no response.
// Clear, append and source words without tlast are taken one per cycle while
// the request side is not held off. A last source word feeds a registered OR
// tree of ceil(log8(PATTERN_DEPTH)) levels that picks the tail cell's count;
// the tree's last level loads the response into the output register, and the
// request side is held off until the tree has drained and the output register
// is free. A stalled response holds its word and keeps the request side held
// off. Reset empties the target and clears all counts and flags.
`timescale 1ns / 1ps
`default_nettype none

module distinct_subsequence_counter #(
   parameter int PATTERN_DEPTH = 128,
   parameter int COUNT_WIDTH   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] symbol
   input  wire logic [1:0]  req_tuser,   // [1:0] action
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] count
   output logic      [1:0]  rsp_tuser    // [0] wrapped, [1] target_overflow
);
   import dsc_pkg::*;

   localparam int                LEN_W  = $clog2(PATTERN_DEPTH + 1);
   localparam logic [LEN_W-1:0]  FULL   = LEN_W'(PATTERN_DEPTH);

   logic                   accept;
   logic                   full;
   cell_ctrl_type          ctrl;
   logic [LEN_W-1:0]       length_ff;
   logic [LEN_W-1:0]       length_in;
   logic                   overflow_ff;
   logic                   overflow_in;
   logic                   emit;
   logic [COUNT_WIDTH-1:0] cnt  [PATTERN_DEPTH];
   logic [COUNT_WIDTH:0]   leaf [PATTERN_DEPTH];
   logic                   tree_valid;
   logic [COUNT_WIDTH:0]   tree_data;
   logic [1:0]             tree_side;
   logic                   tree_busy;
   logic [COUNT_WIDTH-1:0] result;
   logic [31:0]            result32;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_data_ff;
   logic [1:0]             rsp_user_ff;

   assign accept = req_tvalid & req_tready;
   assign full   = length_ff == FULL;
   assign emit   = accept && (req_tuser == ACT_SOURCE) && req_tlast;

   always_comb begin
      ctrl.op     = OP_IDLE;
      ctrl.symbol = req_tdata;
      ctrl.last   = req_tlast;
      length_in   = length_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         case (req_tuser)
            ACT_CLEAR: begin
               ctrl.op     = OP_CLEAR;
               length_in   = '0;
               overflow_in = 1'b0;
            end
            ACT_APPEND: begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  ctrl.op   = OP_APPEND;
                  length_in = length_ff + LEN_W'(1);
               end
            end
            ACT_SOURCE: begin
               ctrl.op = OP_SOURCE;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar k = 0; k < PATTERN_DEPTH; k++) begin : g_cell
      dsc_cell #(
         .COUNT_WIDTH(COUNT_WIDTH),
         .LEN_W      (LEN_W),
         .INDEX      (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .length     (length_ff),
         .below_count((k == 0) ? COUNT_WIDTH'(1) : cnt[(k == 0) ? 0 : k - 1]),
         .count      (cnt[k]),
         .leaf       (leaf[k])
      );
   end

   dsc_or_tree #(
      .LEAVES(PATTERN_DEPTH),
      .WIDTH (COUNT_WIDTH + 1),
      .SIDE_W(2)
   ) u_tree (
      .clock    (clock),
      .reset    (reset),
      .in_valid (emit),
      .leaf     (leaf),
      .side_in  ({overflow_ff, length_ff == '0}),
      .out_valid(tree_valid),
      .out_data (tree_data),
      .side_out (tree_side),
      .busy     (tree_busy)
   );

   assign result = tree_side[0] ? COUNT_WIDTH'(1) : tree_data[COUNT_WIDTH-1:0];

   if (COUNT_WIDTH >= 32) begin : g_wide
      assign result32 = result[31:0];
   end else begin : g_narrow
      assign result32 = {{(32 - COUNT_WIDTH){1'b0}}, result};
   end

   assign req_tready = ~tree_busy & (~rsp_valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (tree_valid) begin
         rsp_data_ff <= result32;
         rsp_user_ff <= {tree_side[1], tree_data[COUNT_WIDTH]};
      end
      if (reset) begin
         length_ff    <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff   <= length_in;
         overflow_ff <= overflow_in;
         if (tree_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      tree_valid |-> !rsp_valid_ff)
      else $error("Response arrived while the output register was occupied.");

   a_length_bound : assert property (@(posedge clock) disable iff (reset)
      length_ff <= FULL)
      else $error("Target length exceeds the cell count.");

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> full)
      else $error("Overflow flag set with free cells left.");

   a_hold_after_last : assert property (@(posedge clock) disable iff (reset)
      emit |=> !req_tready)
      else $error("Request side open while a result is in the tree.");

endmodule

`default_nettype wire
